@@ hdl/met_pkg.sv @@
`timescale 1ns / 1ps

package met_pkg;

  localparam int COORD_W   = 12;
  localparam int COUNT_W   = 16;
  localparam int POINT_W   = 32;
  localparam int STEP_W    = 31;
  localparam int PROD_W    = 2 * POINT_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int MAX_SIDE      = 4096;
  localparam int FRACTION_BITS = 28;

  // |z|^2 >= 4 in the full-width product scale
  localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(64'd1 << (2 * FRACTION_BITS + 2));

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP   = 3'd4;

  localparam logic [COUNT_W-1:0]        RST_MAX_ITER = 16'd1000;
  localparam logic signed [POINT_W-1:0] RST_X_ORIGIN = -32'sd536870912;
  localparam logic [STEP_W-1:0]         RST_X_STEP   = 31'd262144;
  localparam logic signed [POINT_W-1:0] RST_Y_ORIGIN = -32'sd268435456;
  localparam logic [STEP_W-1:0]         RST_Y_STEP   = 31'd131072;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CR,
    ST_CI,
    ST_CIM,
    ST_RR,
    ST_II,
    ST_TEST,
    ST_UPD,
    ST_FIN
  } state_t;

  function automatic logic fits32(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-POINT_W:0] top;
    top = v[PROD_W-1:POINT_W-1];
    return (&top) || !(|top);
  endfunction

  function automatic logic signed [POINT_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [POINT_W-1:0] r;
    if (fits32(v)) begin
      r = v[POINT_W-1:0];
    end else if (v[PROD_W-1]) begin
      r = {1'b1, {(POINT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(POINT_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_index(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (32'(v) >= MAX_SIDE) begin
      r = COORD_W'(MAX_SIDE - 1);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ hdl/met_ifs.sv @@
`timescale 1ns / 1ps

interface met_pix_if;
  logic                        valid;
  logic                        ready;
  logic [met_pkg::COORD_W-1:0] column;
  logic [met_pkg::COORD_W-1:0] row;
  modport source (output valid, column, row, input ready);
  modport sink (input valid, column, row, output ready);
endinterface

interface met_res_if;
  logic                        valid;
  logic                        ready;
  logic [met_pkg::COUNT_W-1:0] escape_count;
  modport source (output valid, escape_count, input ready);
  modport sink (input valid, escape_count, output ready);
endinterface

interface met_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [met_pkg::CFG_IDX_W-1:0] index;
  logic [met_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/met_mul.sv @@
`timescale 1ns / 1ps

module met_mul (
  input  logic                               clk,
  input  logic signed [met_pkg::POINT_W-1:0] a,
  input  logic signed [met_pkg::POINT_W-1:0] b,
  output logic signed [met_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ hdl/mandelbrot_escape_time_top.sv @@
`timescale 1ns / 1ps

// Mandelbrot escape-time counter. Each request names a pixel by column and row; the
// block maps it to c = (x_origin + column*x_step) + i*(y_origin + row*y_step) in signed
// Q4.28 (saturated), iterates z = z*z + c from zero and returns the number of steps
// taken before |z|^2 >= 4, an iterate overflow, or max_iterations. One pixel is worked
// at a time on a single registered 32x32 multiplier that forms zr*zr, zi*zi and zr*zi
// in turn, so each step passes through the states RR, II, TEST and UPD. A new request
// is taken as soon as the previous result sits in the output register.
// Configuration registers are always writable and must be changed only while idle.

module mandelbrot_escape_time_top (
  input logic     clk,
  input logic     rst,
  met_pix_if.sink pix,
  met_res_if.source res,
  met_cfg_if.sink cfg
);

  met_pkg::state_t state, state_next;

  logic [met_pkg::COUNT_W-1:0]        max_iter;
  logic signed [met_pkg::POINT_W-1:0] x_origin;
  logic [met_pkg::STEP_W-1:0]         x_step;
  logic signed [met_pkg::POINT_W-1:0] y_origin;
  logic [met_pkg::STEP_W-1:0]         y_step;

  logic [met_pkg::COORD_W-1:0]        col_q;
  logic [met_pkg::COORD_W-1:0]        row_q;
  logic signed [met_pkg::POINT_W-1:0] c_real;
  logic signed [met_pkg::POINT_W-1:0] c_imag;
  logic signed [met_pkg::POINT_W-1:0] z_real;
  logic signed [met_pkg::POINT_W-1:0] z_imag;
  logic [met_pkg::COUNT_W-1:0]        step_count;
  logic signed [met_pkg::PROD_W-1:0]  sq_rr;
  logic signed [met_pkg::PROD_W-1:0]  diff;

  logic                               res_valid;
  logic [met_pkg::COUNT_W-1:0]        res_count;

  logic signed [met_pkg::POINT_W-1:0] mul_a;
  logic signed [met_pkg::POINT_W-1:0] mul_b;
  logic signed [met_pkg::PROD_W-1:0]  prod;

  logic [met_pkg::PROD_W-1:0]         mag;
  logic                               stop_now;
  logic signed [met_pkg::PROD_W-1:0]  new_real;
  logic signed [met_pkg::PROD_W-1:0]  new_imag;
  logic                               ovf;
  logic                               pix_take;
  logic                               res_load;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= met_pkg::RST_MAX_ITER;
      x_origin <= met_pkg::RST_X_ORIGIN;
      x_step   <= met_pkg::RST_X_STEP;
      y_origin <= met_pkg::RST_Y_ORIGIN;
      y_step   <= met_pkg::RST_Y_STEP;
    end else if (cfg.valid) begin
      case (cfg.index)
        met_pkg::CFG_MAX_ITER: max_iter <= cfg.data[met_pkg::COUNT_W-1:0];
        met_pkg::CFG_X_ORIGIN: x_origin <= cfg.data;
        met_pkg::CFG_X_STEP:   x_step   <= cfg.data[met_pkg::STEP_W-1:0];
        met_pkg::CFG_Y_ORIGIN: y_origin <= cfg.data;
        met_pkg::CFG_Y_STEP:   y_step   <= cfg.data[met_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier
  always_comb begin
    case (state)
      met_pkg::ST_CR: begin
        mul_a = met_pkg::POINT_W'(col_q);
        mul_b = {1'b0, x_step};
      end
      met_pkg::ST_CI: begin
        mul_a = met_pkg::POINT_W'(row_q);
        mul_b = {1'b0, y_step};
      end
      met_pkg::ST_RR: begin
        mul_a = z_real;
        mul_b = z_real;
      end
      met_pkg::ST_II: begin
        mul_a = z_imag;
        mul_b = z_imag;
      end
      default: begin
        mul_a = z_real;
        mul_b = z_imag;
      end
    endcase
  end

  met_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // escape test on the squares of the current z, then the cross term update
  assign mag      = met_pkg::PROD_W'(sq_rr) + met_pkg::PROD_W'(prod);
  assign stop_now = (mag >= met_pkg::ESC_LIMIT) || (step_count >= max_iter);
  assign new_real = (diff >>> met_pkg::FRACTION_BITS) + met_pkg::PROD_W'(c_real);
  assign new_imag = (prod >>> (met_pkg::FRACTION_BITS - 1)) + met_pkg::PROD_W'(c_imag);
  assign ovf      = !met_pkg::fits32(new_real) || !met_pkg::fits32(new_imag);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      met_pkg::ST_IDLE: if (pix.valid) state_next = met_pkg::ST_CR;
      met_pkg::ST_CR:   state_next = met_pkg::ST_CI;
      met_pkg::ST_CI:   state_next = met_pkg::ST_CIM;
      met_pkg::ST_CIM:  state_next = met_pkg::ST_RR;
      met_pkg::ST_RR:   state_next = met_pkg::ST_II;
      met_pkg::ST_II:   state_next = met_pkg::ST_TEST;
      met_pkg::ST_TEST: state_next = stop_now ? met_pkg::ST_FIN : met_pkg::ST_UPD;
      met_pkg::ST_UPD:  state_next = ovf ? met_pkg::ST_FIN : met_pkg::ST_RR;
      met_pkg::ST_FIN:  if (!res_valid || res.ready) state_next = met_pkg::ST_IDLE;
      default:          state_next = met_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pix_take = 1'b0;
    res_load = 1'b0;
    case (state)
      met_pkg::ST_IDLE: pix_take = 1'b1;
      met_pkg::ST_FIN:  res_load = !res_valid || res.ready;
      default: ;
    endcase
  end

  assign pix.ready        = pix_take;
  assign res.valid        = res_valid;
  assign res.escape_count = res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= met_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      met_pkg::ST_IDLE: begin
        col_q <= met_pkg::clamp_index(pix.column);
        row_q <= met_pkg::clamp_index(pix.row);
      end
      met_pkg::ST_CI: begin
        c_real <= met_pkg::sat32({{met_pkg::POINT_W{x_origin[met_pkg::POINT_W-1]}}, x_origin}
                                 + prod);
      end
      met_pkg::ST_CIM: begin
        c_imag     <= met_pkg::sat32({{met_pkg::POINT_W{y_origin[met_pkg::POINT_W-1]}},
                                      y_origin} + prod);
        z_real     <= '0;
        z_imag     <= '0;
        step_count <= '0;
      end
      met_pkg::ST_II: begin
        sq_rr <= prod;
      end
      met_pkg::ST_TEST: begin
        diff <= sq_rr - prod;
      end
      met_pkg::ST_UPD: begin
        // the step counts even when the new iterate overflows
        step_count <= step_count + 1'b1;
        if (!ovf) begin
          z_real <= new_real[met_pkg::POINT_W-1:0];
          z_imag <= new_imag[met_pkg::POINT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_count <= step_count;
    end
  end

`ifndef NO_ASSERTIONS
  a_req_starts: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |=> (state == met_pkg::ST_CR))
    else $error("request did not start the point setup");

  a_step_counts: assert property (@(posedge clk) disable iff (rst)
    (state == met_pkg::ST_UPD) |=> (step_count == $past(step_count) + 1'b1))
    else $error("step count did not advance on an update");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == met_pkg::ST_FIN))
    else $error("result raised outside the finish state");
`endif

endmodule

@@ tb/mandelbrot_escape_time_top_tb.sv @@
`timescale 1ns / 1ps

module mandelbrot_escape_time_top_tb;
  import met_pkg::*;

  localparam int     WATCHDOG_LIMIT = 1_000_000;
  localparam int     REG_COUNT      = 5;
  localparam int     PHASES         = 10;
  localparam int     PHASE_PIXELS   = 60;
  localparam int     LONG_HOLD      = 300;
  localparam longint POINT_MAX      = (longint'(1) << (POINT_W - 1)) - 1;
  localparam longint POINT_MIN      = -(longint'(1) << (POINT_W - 1));
  localparam longint Q_TWO          = longint'(2) << FRACTION_BITS;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } reg_write_t;

  logic clk;
  logic rst = 1'b1;

  met_pix_if pix_if ();
  met_res_if res_if ();
  met_cfg_if cfg_if ();

  mandelbrot_escape_time_top i_dut (
    .clk(clk),
    .rst(rst),
    .pix(pix_if),
    .res(res_if),
    .cfg(cfg_if)
  );

  pixel_t             pixel_queue[$];
  reg_write_t         reg_queue[$];
  logic [COUNT_W-1:0] expected_counts[$];

  int pixels_queued, pixels_taken;
  int regs_queued, regs_taken;
  int errors;
  int quiet_cycles;
  int pix_gap, res_gap, hold_left, hold_req;
  bit idle_on;
  bit pix_taken, cfg_taken;

  // register contents the block should hold
  logic [COUNT_W-1:0]        iter_limit;
  logic signed [POINT_W-1:0] x_org, y_org;
  logic [STEP_W-1:0]         x_inc, y_inc;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic longint clip_point(input longint v);
    if (v > POINT_MAX) return POINT_MAX;
    if (v < POINT_MIN) return POINT_MIN;
    return v;
  endfunction

  function automatic logic [COUNT_W-1:0] escape_steps(input pixel_t p);
    longint             col, row, cr, ci, zr, zi, nr, ni;
    logic [PROD_W-1:0]  mag;
    logic [COUNT_W-1:0] n;
    bit                 gone;
    col = (int'(p.column) >= MAX_SIDE) ? MAX_SIDE - 1 : longint'(p.column);
    row = (int'(p.row) >= MAX_SIDE) ? MAX_SIDE - 1 : longint'(p.row);
    cr = clip_point(longint'(x_org) + col * longint'(x_inc));
    ci = clip_point(longint'(y_org) + row * longint'(y_inc));
    zr = 0;
    zi = 0;
    n = '0;
    gone = 1'b0;
    while (n < iter_limit && !gone) begin
      nr = ((zr * zr - zi * zi) >>> FRACTION_BITS) + cr;
      ni = ((zr * zi) >>> (FRACTION_BITS - 1)) + ci;
      n++;
      if (nr > POINT_MAX || nr < POINT_MIN || ni > POINT_MAX || ni < POINT_MIN) begin
        // overflowed iterate still counts and ends the loop
        gone = 1'b1;
      end else begin
        zr = nr;
        zi = ni;
        mag = PROD_W'(nr * nr) + PROD_W'(ni * ni);
        gone = (mag >= ESC_LIMIT);
      end
    end
    return n;
  endfunction

  task automatic add_pixel(input int unsigned column, input int unsigned row);
    pixel_queue.push_back('{COORD_W'(column), COORD_W'(row)});
    pixels_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DAT_W-1:0] data);
    reg_queue.push_back('{index, data});
    regs_queued++;
  endtask

  // wait until every request is taken and every result is back
  task automatic settle();
    while (pixel_queue.size() != 0 || pixels_taken != pixels_queued ||
           expected_counts.size() != 0 || reg_queue.size() != 0 || regs_taken != regs_queued)
      @(posedge clk);
  endtask

  task automatic pick_view();
    int          view;
    int          x0, y0;
    int unsigned xs, ys, lim;
    view = $urandom_range(0, 3);
    if (view == 0) begin
      x0 = int'($urandom);
      y0 = int'($urandom);
      xs = $urandom;
      ys = $urandom;
    end else if (view == 1) begin
      // tight window near the boundary of the set
      x0 = -(3 << 26) + int'($urandom_range(0, 1 << 24)) - (1 << 23);
      y0 = (1 << 25) + int'($urandom_range(0, 1 << 24)) - (1 << 23);
      xs = $urandom_range(1, 1 << 12);
      ys = $urandom_range(1, 1 << 12);
    end else begin
      // window starting near the left and lower edge of the set
      x0 = -(5 << 27) + int'($urandom_range(0, 1 << 28));
      y0 = -(5 << 26) + int'($urandom_range(0, 1 << 27));
      xs = {1'($urandom), 31'($urandom_range(1 << 14, 1 << 18))};
      ys = {1'($urandom), 31'($urandom_range(1 << 13, 1 << 17))};
    end
    lim = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 400) : $urandom_range(1, 64);
    write_reg(CFG_MAX_ITER, {16'($urandom), COUNT_W'(lim)});
    write_reg(CFG_X_ORIGIN, CFG_DAT_W'(x0));
    write_reg(CFG_X_STEP, CFG_DAT_W'(xs));
    write_reg(CFG_Y_ORIGIN, CFG_DAT_W'(y0));
    write_reg(CFG_Y_STEP, CFG_DAT_W'(ys));
  endtask

  always @(negedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
      pix_gap = 0;
    end else if (!pix_if.valid || pix_taken) begin
      if (pix_gap != 0) begin
        pix_gap--;
        pix_if.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        pix_gap = $urandom_range(0, 14);
        pix_if.valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        pix_if.valid  <= 1'b1;
        pix_if.column <= pixel_queue[0].column;
        pix_if.row    <= pixel_queue[0].row;
        void'(pixel_queue.pop_front());
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (hold_req != 0) begin
      hold_left = hold_req - 1;
      hold_req = 0;
      res_if.ready <= 1'b0;
    end else if (res_gap != 0) begin
      res_gap--;
      res_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      res_gap = $urandom_range(0, 14);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      cfg_if.valid <= 1'b0;
    end else if (!cfg_if.valid || cfg_taken) begin
      if (reg_queue.size() != 0) begin
        cfg_if.valid <= 1'b1;
        cfg_if.index <= reg_queue[0].index;
        cfg_if.data  <= reg_queue[0].data;
        void'(reg_queue.pop_front());
      end else begin
        cfg_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    logic [COUNT_W-1:0] due;
    pix_taken <= pix_if.valid && pix_if.ready;
    cfg_taken <= cfg_if.valid && cfg_if.ready;
    if (rst) begin
      iter_limit = RST_MAX_ITER;
      x_org      = RST_X_ORIGIN;
      x_inc      = RST_X_STEP;
      y_org      = RST_Y_ORIGIN;
      y_inc      = RST_Y_STEP;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_MAX_ITER: iter_limit = cfg_if.data[COUNT_W-1:0];
          CFG_X_ORIGIN: x_org = cfg_if.data;
          CFG_X_STEP:   x_inc = cfg_if.data[STEP_W-1:0];
          CFG_Y_ORIGIN: y_org = cfg_if.data;
          CFG_Y_STEP:   y_inc = cfg_if.data[STEP_W-1:0];
          default: ;
        endcase
        regs_taken++;
      end
      if (pix_if.valid && pix_if.ready) begin
        expected_counts.push_back(escape_steps('{pix_if.column, pix_if.row}));
        pixels_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_counts.size() == 0) begin
          $error("escape_count: expected none, actual %0d", res_if.escape_count);
          errors++;
        end else begin
          due = expected_counts.pop_front();
          if (res_if.escape_count !== due) begin
            $error("escape_count: expected %0d, actual %0d", due, res_if.escape_count);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned column, row;
    pix_if.valid  = 1'b0;
    pix_if.column = '0;
    pix_if.row    = '0;
    res_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    idle_on       = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset view: corners, alternating bits, and c = 0 running to the limit
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(2048, 2048);
    add_pixel(4095, 0);
    add_pixel(0, 4095);
    add_pixel('haaa, 'h555);
    add_pixel('h555, 'haaa);
    settle();

    // writes to unused indexes must not land, then a zero limit
    for (int k = 0; k < 3; k++) write_reg(CFG_IDX_W'(REG_COUNT + k), $urandom);
    write_reg(CFG_MAX_ITER, '0);
    settle();
    add_pixel(0, 0);
    add_pixel(2048, 2048);
    settle();

    // extreme origins and steps, c saturates; upper data bits must be dropped
    write_reg(CFG_MAX_ITER, {16'hffff, COUNT_W'(5)});
    write_reg(CFG_X_ORIGIN, CFG_DAT_W'(POINT_MIN));
    write_reg(CFG_X_STEP, '1);
    write_reg(CFG_Y_ORIGIN, CFG_DAT_W'(POINT_MAX));
    write_reg(CFG_Y_STEP, '1);
    settle();
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(1, 0);
    add_pixel(0, 1);
    settle();

    // escape right on |z|^2 = 4, just inside it, and the largest limit at c = 0
    write_reg(CFG_MAX_ITER, '1);
    write_reg(CFG_X_ORIGIN, CFG_DAT_W'(Q_TWO));
    write_reg(CFG_X_STEP, '0);
    write_reg(CFG_Y_ORIGIN, '0);
    write_reg(CFG_Y_STEP, '0);
    settle();
    add_pixel(7, 9);
    settle();
    write_reg(CFG_X_ORIGIN, CFG_DAT_W'(Q_TWO - 1));
    settle();
    add_pixel(0, 0);
    settle();
    write_reg(CFG_X_ORIGIN, '0);
    write_reg(CFG_Y_ORIGIN, CFG_DAT_W'(-Q_TWO));
    settle();
    add_pixel(3, 3);
    settle();
    write_reg(CFG_Y_ORIGIN, '0);
    settle();
    add_pixel(0, 0);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      pick_view();
      settle();
      if (ph == PHASES - 1) idle_on = 1'b0;
      // receiver stalls long so the block backs up on its input
      if (ph == 0) hold_req = LONG_HOLD;
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        column = $urandom_range(0, 4095);
        row    = $urandom_range(0, 4095);
        if ($urandom_range(0, 15) == 0) column = $urandom_range(0, 1) ? 4095 : 0;
        if ($urandom_range(0, 15) == 0) row = $urandom_range(0, 1) ? 4095 : 0;
        add_pixel(column, row);
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_counts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
